### hdl/distance_vector_table_merge_core_macros.svh
// Assertion helpers used by the checker file.
`ifndef DISTANCE_VECTOR_TABLE_MERGE_CORE_MACROS_SVH
`define DISTANCE_VECTOR_TABLE_MERGE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clock, quiet during reset.
`define DVTM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, quiet during reset.
`define DVTM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/dvtm_pkg.sv
package dvtm_pkg;

   localparam int SLOT_FIELD_W = 7;
   localparam int CSR_INDEX_W  = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_ADDRESS = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_LENGTH  = 4'd1;

   localparam logic [5:0] OWN_LENGTH_RESET = 6'd32;
   localparam logic [7:0] DISTANCE_MAX     = 8'hFF;

   typedef enum logic [1:0] {
      OUTCOME_IMPROVED  = 2'd0,
      OUTCOME_UNCHANGED = 2'd1,
      OUTCOME_INSERTED  = 2'd2,
      OUTCOME_FULL      = 2'd3
   } outcome_type;

   typedef struct packed {
      logic [31:0] route_address;
      logic [5:0]  route_length;
      logic [7:0]  advertised_distance;
   } req_type;

   typedef struct packed {
      outcome_type             outcome;
      logic [SLOT_FIELD_W-1:0] entry_slot;
      logic [7:0]              route_distance;
      logic [7:0]              route_count;
   } rsp_type;

   // Search request walking down the cell chain.
   typedef struct packed {
      logic [31:0]             address;
      logic [5:0]              length;
      logic [7:0]              cand_distance;
      logic                    found;
      logic                    inserted;
      logic                    improved;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [7:0]              distance;
   } token_type;

endpackage

### hdl/dvtm_cell.sv
module dvtm_cell #(
   parameter int SLOT    = 1,
   parameter int COUNT_W = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [COUNT_W-1:0]   entry_count,
   input  logic                 tok_vld_i,
   input  dvtm_pkg::token_type  tok_i,
   output logic                 tok_vld_o,
   output dvtm_pkg::token_type  tok_o
);

   logic [31:0]         entry_addr_ff;
   logic [5:0]          entry_len_ff;
   logic [7:0]          entry_dist_ff;
   logic                tok_vld_ff;
   dvtm_pkg::token_type tok_ff;
   dvtm_pkg::token_type tok_in;

   logic live;
   logic held;
   logic hit;
   logic ins;
   logic better;

   always_comb begin
      live   = tok_vld_i && !tok_i.found && !tok_i.inserted;
      held   = COUNT_W'(SLOT) < entry_count;
      hit    = live && held && (entry_addr_ff == tok_i.address)
               && (entry_len_ff == tok_i.length);
      // first free slot: every valid slot below has already missed
      ins    = live && (COUNT_W'(SLOT) == entry_count);
      better = tok_i.cand_distance < entry_dist_ff;

      tok_in = tok_i;
      if (hit) begin
         tok_in.found = 1'b1;
         tok_in.slot  = dvtm_pkg::SLOT_FIELD_W'(SLOT);
         if (better) begin
            tok_in.improved = 1'b1;
            tok_in.distance = tok_i.cand_distance;
         end else begin
            tok_in.distance = entry_dist_ff;
         end
      end else if (ins) begin
         tok_in.inserted = 1'b1;
         tok_in.slot     = dvtm_pkg::SLOT_FIELD_W'(SLOT);
         tok_in.distance = tok_i.cand_distance;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_vld_ff <= 1'b0;
      end else begin
         tok_vld_ff <= tok_vld_i;
      end
      tok_ff <= tok_in;
      if (ins) begin
         entry_addr_ff <= tok_i.address;
         entry_len_ff  <= tok_i.length;
         entry_dist_ff <= tok_i.cand_distance;
      end else if (hit && better) begin
         entry_dist_ff <= tok_i.cand_distance;
      end
   end

   assign tok_vld_o = tok_vld_ff;
   assign tok_o     = tok_ff;

endmodule

### hdl/distance_vector_table_merge_core.sv
// Route table merge for a distance-vector router.
// req_*: one advertised route (address, length, distance) per request.
// rsp_*: one result per request: outcome, slot, stored distance, entry count.
// csr_*: writes the own prefix address (index 0) and length (index 1); always
//   ready, and meant to be written only while no request is in flight.
// Slot 0 is the own route at distance 0; slots 1 to TABLE_ENTRIES-1 live in a
// chain of cells, one entry each. A request walks the chain one cell per
// cycle, and its result is then registered in the response register. A new
// request is taken only after the previous one has left the chain and while
// the skid register is empty, so only one request is in flight at a time.
// A finished result sits in the response register; if the receiver stalls,
// one more result waits in a skid register and new requests wait until the
// skid register drains.
// Reset empties the table (entry count 1), sets the own prefix to 0.0.0.0/32
// and drops any request in flight. No clearing pass is needed.
module distance_vector_table_merge_core #(
   parameter int TABLE_ENTRIES = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  dvtm_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output dvtm_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dvtm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [31:0]                         csr_wdata
);

   localparam int COUNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int CELLS   = TABLE_ENTRIES - 1;

   logic [31:0]         own_addr_ff;
   logic [5:0]          own_len_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [COUNT_W-1:0]  count_in;
   logic                busy_ff;
   logic                launch_vld_ff;
   dvtm_pkg::token_type launch_ff;
   dvtm_pkg::token_type launch_in;
   logic                rsp_vld_ff;
   dvtm_pkg::rsp_type   rsp_ff;
   logic                skid_vld_ff;
   dvtm_pkg::rsp_type   skid_ff;

   logic                chain_vld [CELLS+1];
   dvtm_pkg::token_type chain_tok [CELLS+1];

   logic                req_fire;
   logic                rsp_free;
   logic                exit_vld;
   dvtm_pkg::token_type exit_tok;
   dvtm_pkg::rsp_type   result;

   assign req_ready = !busy_ff && !skid_vld_ff;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_vld_ff || rsp_ready;

   always_comb begin
      launch_in.address       = req_data.route_address;
      launch_in.length        = req_data.route_length;
      launch_in.cand_distance = (req_data.advertised_distance == dvtm_pkg::DISTANCE_MAX)
                                ? dvtm_pkg::DISTANCE_MAX
                                : req_data.advertised_distance + 8'd1;
      // own route matches in slot 0 and is never changed
      launch_in.found    = (req_data.route_address == own_addr_ff)
                           && (req_data.route_length == own_len_ff);
      launch_in.inserted = 1'b0;
      launch_in.improved = 1'b0;
      launch_in.slot     = '0;
      launch_in.distance = '0;
   end

   assign chain_vld[0] = launch_vld_ff;
   assign chain_tok[0] = launch_ff;

   for (genvar g = 1; g <= CELLS; g++) begin : g_cell
      dvtm_cell #(
         .SLOT    (g),
         .COUNT_W (COUNT_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .entry_count (count_ff),
         .tok_vld_i   (chain_vld[g-1]),
         .tok_i       (chain_tok[g-1]),
         .tok_vld_o   (chain_vld[g]),
         .tok_o       (chain_tok[g])
      );
   end

   assign exit_vld = chain_vld[CELLS];
   assign exit_tok = chain_tok[CELLS];

   always_comb begin
      count_in = count_ff + COUNT_W'(exit_tok.inserted);
      result.route_count = 8'(count_in);
      if (exit_tok.found) begin
         result.outcome        = exit_tok.improved ? dvtm_pkg::OUTCOME_IMPROVED
                                                   : dvtm_pkg::OUTCOME_UNCHANGED;
         result.entry_slot     = exit_tok.slot;
         result.route_distance = exit_tok.distance;
      end else if (exit_tok.inserted) begin
         result.outcome        = dvtm_pkg::OUTCOME_INSERTED;
         result.entry_slot     = exit_tok.slot;
         result.route_distance = exit_tok.distance;
      end else begin
         result.outcome        = dvtm_pkg::OUTCOME_FULL;
         result.entry_slot     = '0;
         result.route_distance = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_addr_ff   <= '0;
         own_len_ff    <= dvtm_pkg::OWN_LENGTH_RESET;
         count_ff      <= COUNT_W'(1);
         busy_ff       <= 1'b0;
         launch_vld_ff <= 1'b0;
         rsp_vld_ff    <= 1'b0;
         skid_vld_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               dvtm_pkg::CSR_OWN_ADDRESS: own_addr_ff <= csr_wdata;
               dvtm_pkg::CSR_OWN_LENGTH:  own_len_ff  <= csr_wdata[5:0];
               default: ;
            endcase
         end

         launch_vld_ff <= req_fire;
         if (req_fire) begin
            busy_ff <= 1'b1;
         end else if (exit_vld) begin
            busy_ff  <= 1'b0;
         end
         if (exit_vld) begin
            count_ff <= count_in;
         end

         // park the result in the skid register while the receiver stalls
         if (exit_vld) begin
            if (rsp_free) begin
               rsp_vld_ff <= 1'b1;
            end else begin
               skid_vld_ff <= 1'b1;
            end
         end else if (skid_vld_ff && rsp_free) begin
            rsp_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end

      if (req_fire) begin
         launch_ff <= launch_in;
      end
      if (exit_vld) begin
         if (rsp_free) begin
            rsp_ff <= result;
         end else begin
            skid_ff <= result;
         end
      end else if (skid_vld_ff && rsp_free) begin
         rsp_ff <= skid_ff;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

### hdl/dvtm_checker.sv
`include "distance_vector_table_merge_core_macros.svh"

module dvtm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input dvtm_pkg::rsp_type rsp_data
);

   `DVTM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response dropped or changed while stalled")

   `DVTM_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "second request taken while search in flight")

   `DVTM_ASSERT_NOW(a_full_zero, rsp_valid && (rsp_data.outcome == dvtm_pkg::OUTCOME_FULL), (rsp_data.entry_slot == '0) && (rsp_data.route_distance == '0), "dropped route reports slot or distance")

   `DVTM_ASSERT_NOW(a_insert_slot, rsp_valid && (rsp_data.outcome == dvtm_pkg::OUTCOME_INSERTED), (rsp_data.entry_slot == 7'(rsp_data.route_count - 8'd1)) && (rsp_data.route_distance != 8'd0), "inserted slot disagrees with entry count")

endmodule

bind distance_vector_table_merge_core dvtm_checker u_dvtm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
